>>> rtl/core/pst_pkg.sv
`default_nettype none
package pst_pkg;

    typedef struct packed {
        logic signed [31:0] setpoint;
        logic        [30:0] time_step;
        logic signed [31:0] inflow_speed;
        logic        [30:0] fluid_density;
        logic               in_fluid;
    } pst_in_t;

    typedef struct packed {
        logic signed [31:0] rotor_speed;
        logic signed [31:0] rotor_angle;
        logic signed [31:0] thrust_out;
        logic signed [31:0] load_torque;
    } pst_out_t;

    localparam logic [2:0] REG_GAIN_P     = 3'd0;
    localparam logic [2:0] REG_GAIN_I     = 3'd1;
    localparam logic [2:0] REG_SPEED_LIM  = 3'd2;
    localparam logic [2:0] REG_DIAMETER   = 3'd3;
    localparam logic [2:0] REG_KT_FWD     = 3'd4;
    localparam logic [2:0] REG_KT_REV     = 3'd5;
    localparam logic [2:0] REG_KQ         = 3'd6;
    localparam logic [2:0] REG_MODE       = 3'd7;

    localparam logic signed [31:0] ONE_Q        = 32'sd65536;
    localparam logic signed [31:0] INV_TWO_PI_Q = 32'sd10430;
    localparam logic signed [31:0] ALPHA_Q      = -32'sd7782;
    localparam logic signed [31:0] INT_LIMIT    = 32'sd131072;

    typedef enum logic [1:0] {
        MS_IDLE,
        MS_RUN,
        MS_DONE
    } mul_state_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_WAIT,
        ST_OUT
    } seq_state_t;

    // Saturate a 33-bit signed sum to 32 bits.
    function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
        logic signed [31:0] r;
        begin
            if (v[32] != v[31])
                r = v[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
            else
                r = v[31:0];
            return r;
        end
    endfunction

endpackage
`default_nettype wire

>>> rtl/core/pst_serial_mul.sv
`default_nettype none
// Bit-serial signed Q16.16 multiplier: one multiplier bit per cycle,
// result floored and saturated to 32 bits.
module pst_serial_mul
    import pst_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic signed [31:0] op_a,
    input  wire logic signed [31:0] op_b,
    output logic                    done,
    output logic signed [31:0]      product
);

    mul_state_t         state_reg, state_next;
    logic [5:0]         cnt_reg, cnt_next;
    logic signed [63:0] acc_reg, acc_next;
    logic signed [63:0] mcand_reg, mcand_next;
    logic [31:0]        mplier_reg, mplier_next;
    logic signed [47:0] q;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= MS_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        done        = 1'b0;
        case (state_reg)
            MS_IDLE:
            begin
                if (start)
                begin
                    acc_next    = '0;
                    mcand_next  = 64'(op_a);
                    mplier_next = op_b;
                    cnt_next    = '0;
                    state_next  = MS_RUN;
                end
            end
            MS_RUN:
            begin
                // The top bit of the multiplier carries negative weight.
                if (mplier_reg[0])
                begin
                    if (cnt_reg == 6'd31)
                        acc_next = acc_reg - mcand_reg;
                    else
                        acc_next = acc_reg + mcand_reg;
                end
                mcand_next  = mcand_reg <<< 1;
                mplier_next = mplier_reg >> 1;
                cnt_next    = cnt_reg + 6'd1;
                if (cnt_reg == 6'd31)
                    state_next = MS_DONE;
            end
            MS_DONE:
            begin
                done       = 1'b1;
                state_next = MS_IDLE;
            end
            default: state_next = MS_IDLE;
        endcase
    end

    assign q = acc_reg[63:16];

    always_comb
    begin
        if (q > 48'sh0000_7fff_ffff)
            product = 32'sh7fff_ffff;
        else if (q < -48'sh0000_8000_0000)
            product = 32'sh8000_0000;
        else
            product = q[31:0];
    end

endmodule
`default_nettype wire

>>> rtl/core/propeller_speed_pi_thrust_unit.sv
`default_nettype none
// Channel | Direction | Handshake            | Word
// in      | input     | in_valid / in_stall  | pst_in_t
// out     | output    | out_valid / out_stall| pst_out_t
// cfg     | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// An item in the fluid takes 20 multiplications on one bit-serial multiplier,
// each an issue, a shift-and-add step per multiplier bit and a done; out of
// the fluid only the first six run. The sequencer feeds all of them to the
// shared multiplier. Reset zeroes the sequencer and controller state and sets
// the configuration registers to their defaults, but not the item latch or
// scratch registers. A finished word waits on the output in the state regs; a
// new item is taken only once out_valid is low, and a stall holds the word.
module propeller_speed_pi_thrust_unit
    import pst_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire pst_in_t     in_word,
    output logic             out_valid,
    input  wire logic        out_stall,
    output pst_out_t         out_word,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);

    // Configuration registers.
    logic signed [31:0] gain_p_reg, gain_i_reg, speed_lim_reg, diam_reg;
    logic signed [31:0] kt_fwd_reg, kt_rev_reg, kq_reg;
    logic [1:0]         mode_reg;

    // Controller state.
    logic signed [31:0] speed_reg, angle_reg, integ_reg, thrust_reg, torque_reg;

    // Item latch and scratch registers.
    pst_in_t            item_reg;
    logic signed [31:0] t_reg [0:7];
    seq_state_t         state_reg, state_next;
    logic [4:0]         step_reg;
    logic               out_valid_reg;

    logic               mul_start, mul_done;
    logic signed [31:0] mul_a, mul_b, mul_p;
    logic signed [31:0] sp_neg, sp_c;
    logic signed [31:0] integ_sum;
    logic               rh;

    assign cfg_ready = 1'b1;
    assign rh        = mode_reg[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_p_reg    <= 32'sd524288;
            gain_i_reg    <= 32'sd196608;
            speed_lim_reg <= '0;
            diam_reg      <= '0;
            kt_fwd_reg    <= '0;
            kt_rev_reg    <= '0;
            kq_reg        <= '0;
            mode_reg      <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_GAIN_P:    gain_p_reg    <= {1'b0, cfg_data[30:0]};
                REG_GAIN_I:    gain_i_reg    <= {1'b0, cfg_data[30:0]};
                REG_SPEED_LIM: speed_lim_reg <= {1'b0, cfg_data[30:0]};
                REG_DIAMETER:  diam_reg      <= {1'b0, cfg_data[30:0]};
                REG_KT_FWD:    kt_fwd_reg    <= cfg_data;
                REG_KT_REV:    kt_rev_reg    <= cfg_data;
                REG_KQ:        kq_reg        <= cfg_data;
                REG_MODE:      mode_reg      <= cfg_data[1:0];
                default:       ;
            endcase
        end
    end

    pst_serial_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .done    (mul_done),
        .product (mul_p)
    );

    // Setpoint conditioning: saturating negate when mode bit 1 is set, then clamp to plus or minus one.
    assign sp_neg = mode_reg[1] ? sat33(-33'(item_reg.setpoint)) : item_reg.setpoint;
    always_comb
    begin
        if (sp_neg > ONE_Q)
            sp_c = ONE_Q;
        else if (sp_neg < -ONE_Q)
            sp_c = -ONE_Q;
        else
            sp_c = sp_neg;
    end

    // Scratch usage: t0 err, t1 Kp*err, t2 n, t3 d2, t4 d3, t5 general,
    // t6 inner partial, t7 general.
    // Operand selection per step of the sequence.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (step_reg)
            5'd0:  begin mul_a = sp_c;       mul_b = speed_lim_reg; end
            5'd1:  begin mul_a = gain_p_reg; mul_b = t_reg[0]; end
            5'd2:  begin mul_a = gain_i_reg; mul_b = integ_reg; end
            5'd3:  begin mul_a = t_reg[5];   mul_b = {1'b0, item_reg.time_step}; end
            5'd4:  begin mul_a = speed_reg;  mul_b = {1'b0, item_reg.time_step}; end
            5'd5:  begin mul_a = t_reg[0];   mul_b = {1'b0, item_reg.time_step}; end
            5'd6:  begin mul_a = speed_reg;  mul_b = INV_TWO_PI_Q; end
            5'd7:  begin mul_a = diam_reg;   mul_b = diam_reg; end
            5'd8:  begin mul_a = t_reg[3];   mul_b = diam_reg; end
            5'd9:  begin mul_a = diam_reg;   mul_b = t_reg[5]; end
            5'd10: begin mul_a = t_reg[6];   mul_b = t_reg[2]; end
            5'd11: begin mul_a = ALPHA_Q;    mul_b = item_reg.inflow_speed; end
            5'd12: begin mul_a = {1'b0, item_reg.fluid_density}; mul_b = t_reg[4]; end
            5'd13: begin mul_a = t_reg[7];   mul_b = t_reg[5]; end
            5'd14: begin mul_a = t_reg[7];   mul_b = t_reg[6]; end
            5'd15: begin mul_a = kq_reg;     mul_b = {1'b0, item_reg.fluid_density}; end
            5'd16: begin mul_a = t_reg[7];   mul_b = t_reg[5]; end
            5'd17: begin mul_a = t_reg[7];   mul_b = t_reg[2]; end
            5'd18: begin mul_a = t_reg[4];   mul_b = t_reg[3]; end
            5'd19: begin mul_a = t_reg[7];   mul_b = t_reg[6]; end
            default: ;
        endcase
    end

    assign mul_start = (state_reg == ST_ISSUE);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (in_valid && !out_valid_reg) state_next = ST_ISSUE;
            ST_ISSUE: state_next = ST_WAIT;
            ST_WAIT:
            begin
                if (mul_done)
                begin
                    if (step_reg == 5'd19 || (step_reg == 5'd5 && !item_reg.in_fluid))
                        state_next = ST_OUT;
                    else
                        state_next = ST_ISSUE;
                end
            end
            ST_OUT:   state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Integral update before the clamp to plus or minus two.
    assign integ_sum = sat33(33'(integ_reg) + 33'(mul_p));

    logic signed [31:0] an_v, kt_v;
    always_comb
    begin
        an_v = (t_reg[2] < 0) ? sat33(-33'(t_reg[2])) : t_reg[2];
        kt_v = ((rh && speed_reg < 0) || (!rh && speed_reg > 0)) ? kt_rev_reg : kt_fwd_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
            speed_reg     <= '0;
            angle_reg     <= '0;
            integ_reg     <= '0;
            thrust_reg    <= '0;
            torque_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    step_reg <= '0;
                    if (in_valid && !out_valid_reg)
                        item_reg <= in_word;
                end
                ST_WAIT:
                begin
                    if (mul_done)
                    begin
                        step_reg <= step_reg + 5'd1;
                        case (step_reg)
                            5'd0:  t_reg[0] <= sat33(33'(mul_p) - 33'(speed_reg));
                            5'd1:  t_reg[1] <= mul_p;
                            5'd2:  t_reg[5] <= sat33(sat33(33'(t_reg[1]) + 33'(mul_p))
                                                     - 33'(torque_reg));
                            5'd3:  speed_reg <= sat33(33'(speed_reg) + 33'(mul_p));
                            5'd4:  angle_reg <= angle_reg + mul_p;
                            5'd5:
                            begin
                                if (integ_sum > INT_LIMIT)
                                    integ_reg <= INT_LIMIT;
                                else if (integ_sum < -INT_LIMIT)
                                    integ_reg <= -INT_LIMIT;
                                else
                                    integ_reg <= integ_sum;
                                t_reg[5] <= kt_v;
                            end
                            5'd6:  t_reg[2] <= mul_p;
                            5'd7:  t_reg[3] <= mul_p;
                            5'd8:  t_reg[4] <= mul_p;
                            5'd9:  t_reg[6] <= mul_p;
                            5'd10: t_reg[6] <= mul_p;
                            5'd11:
                            begin
                                t_reg[6] <= sat33(33'(t_reg[6]) + 33'(mul_p));
                                t_reg[5] <= an_v;
                            end
                            5'd12: t_reg[7] <= mul_p;
                            5'd13: t_reg[7] <= mul_p;
                            5'd14:
                            begin
                                thrust_reg <= rh ? mul_p : sat33(-33'(mul_p));
                            end
                            5'd15: t_reg[7] <= mul_p;
                            5'd16: t_reg[7] <= mul_p;
                            5'd17: t_reg[7] <= mul_p;
                            5'd18: t_reg[6] <= mul_p;
                            5'd19: torque_reg <= sat33(-33'(mul_p));
                            default: ;
                        endcase
                    end
                end
                ST_OUT: out_valid_reg <= 1'b1;
                default: ;
            endcase
        end
    end

    assign in_stall  = (state_reg != ST_IDLE) || out_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_word  = '{rotor_speed: speed_reg, rotor_angle: angle_reg,
                         thrust_out: thrust_reg, load_torque: torque_reg};

    // The state only moves while an item is being worked on.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && !(in_valid && !out_valid_reg)) |=> $stable(speed_reg))
        else $error("speed changed while idle");
    assert property (@(posedge clk) disable iff (!rst_n)
        (integ_reg <= INT_LIMIT) && (integ_reg >= -INT_LIMIT))
        else $error("integral out of range");
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> in_stall)
        else $error("input taken while a word waits");

endmodule
`default_nettype wire
